/* design/bdfsb_pkg.sv */
// shared types and constants for the balanced dual fifo on one shared buffer
// no dependencies; imported by the top level
`default_nettype none

package bdfsb_pkg;

  // buffer size in words, shared by both queues
  localparam int DEPTH = 16;
  // bits of a cell index and of an occupancy count
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // width of the count fields of a result item
  localparam int OUT_CNT_W = 5;

  // request codes
  localparam logic [1:0] REQ_ENQ     = 2'd0;
  localparam logic [1:0] REQ_DEQ_ONE = 2'd1;
  localparam logic [1:0] REQ_DEQ_TWO = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
  } req_item_t;

  typedef struct packed {
    logic                 ok;
    logic                 head_one_valid;
    logic signed [31:0]   head_one_value;
    logic                 head_two_valid;
    logic signed [31:0]   head_two_value;
    logic [OUT_CNT_W-1:0] count_one;
    logic [OUT_CNT_W-1:0] count_two;
  } rsp_item_t;

endpackage

`default_nettype wire

/* design/balanced_dual_fifo_shared_buffer_unit.sv */
// balanced dual fifo: two queues in one register buffer, one from each end
// depends on bdfsb_pkg for types, buffer size and request codes
`default_nettype none

// the result item of a request is registered and offered in the cycle after acceptance
// throughput: one request per cycle while the result register is free or its item is taken;
// on a dequeue the cells of that queue shift in parallel and the occupancy counts update in the same cycle
// reset: rst_n (synchronous, active low) empties both queues and the result
// register; cell contents are not cleared
module balanced_dual_fifo_shared_buffer_unit
  import bdfsb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire req_item_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rsp_item_t      out_data
);

  logic [31:0]      cells_r   [DEPTH];
  logic [31:0]      cells_nxt [DEPTH];
  logic [31:0]      src_up    [DEPTH];
  logic [31:0]      src_dn    [DEPTH];
  logic [CNT_W-1:0] occ_one_r, occ_one_nxt;
  logic [CNT_W-1:0] occ_two_r, occ_two_nxt;
  logic             out_valid_r;
  rsp_item_t        out_data_r, out_data_nxt;
  logic             accept;
  logic             full;
  logic             to_one;
  logic             ok;

  // handshake: the result register frees as soon as its item is taken
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // full when both queues together fill the buffer; balance picks the target
  assign full   = ({1'b0, occ_one_r} + {1'b0, occ_two_r}) >= (CNT_W+1)'(DEPTH);
  assign to_one = occ_one_r <= occ_two_r;

  // occupancy update and success flag
  always_comb begin
    occ_one_nxt = occ_one_r;
    occ_two_nxt = occ_two_r;
    ok          = 1'b0;
    unique case (in_data.req_type)
      REQ_ENQ: begin
        if (!full) begin
          ok = 1'b1;
          if (to_one) begin
            occ_one_nxt = occ_one_r + 1'b1;
          end else begin
            occ_two_nxt = occ_two_r + 1'b1;
          end
        end
      end
      REQ_DEQ_ONE: begin
        if (occ_one_r != '0) begin
          ok          = 1'b1;
          occ_one_nxt = occ_one_r - 1'b1;
        end
      end
      REQ_DEQ_TWO: begin
        if (occ_two_r != '0) begin
          ok          = 1'b1;
          occ_two_nxt = occ_two_r - 1'b1;
        end
      end
      REQ_CLEAR: begin
        ok          = 1'b1;
        occ_one_nxt = '0;
        occ_two_nxt = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // per-cell next value: write on enqueue, shift toward the end on dequeue
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k < DEPTH - 1) begin : g_up
      assign src_up[k] = cells_r[k+1];
    end else begin : g_up_end
      assign src_up[k] = cells_r[k];
    end
    if (k > 0) begin : g_dn
      assign src_dn[k] = cells_r[k-1];
    end else begin : g_dn_end
      assign src_dn[k] = cells_r[k];
    end

    always_comb begin
      cells_nxt[k] = cells_r[k];
      unique case (in_data.req_type)
        REQ_ENQ: begin
          if (!full) begin
            if (to_one && occ_one_r == CNT_W'(k)) begin
              cells_nxt[k] = in_data.item_value;
            end else if (!to_one && occ_two_r == CNT_W'(DEPTH - 1 - k)) begin
              cells_nxt[k] = in_data.item_value;
            end
          end
        end
        REQ_DEQ_ONE: begin
          // only cells still inside queue one move
          if ((CNT_W+1)'(k + 1) < {1'b0, occ_one_r}) begin
            cells_nxt[k] = src_up[k];
          end
        end
        REQ_DEQ_TWO: begin
          if ((CNT_W+1)'(k) + {1'b0, occ_two_r} > (CNT_W+1)'(DEPTH)) begin
            cells_nxt[k] = src_dn[k];
          end
        end
        default: begin
          cells_nxt[k] = cells_r[k];
        end
      endcase
    end
  end

  // result item from the state after this request
  always_comb begin
    out_data_nxt.ok             = ok;
    out_data_nxt.head_one_valid = occ_one_nxt != '0;
    out_data_nxt.head_one_value = (occ_one_nxt != '0) ? cells_nxt[0] : '0;
    out_data_nxt.head_two_valid = occ_two_nxt != '0;
    out_data_nxt.head_two_value = (occ_two_nxt != '0) ? cells_nxt[DEPTH-1] : '0;
    out_data_nxt.count_one      = OUT_CNT_W'(occ_one_nxt);
    out_data_nxt.count_two      = OUT_CNT_W'(occ_two_nxt);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_one_r   <= '0;
      occ_two_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_one_r   <= occ_one_nxt;
        occ_two_r   <= occ_two_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // buffer cells and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cells_r    <= cells_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  // the two queues never overlap in the buffer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, occ_one_r} + {1'b0, occ_two_r}) <= (CNT_W+1)'(DEPTH))
    else $error("queue occupancies exceed buffer size");

  // a clear empties both queues in the next result
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_CLEAR) |=>
      (out_valid && out_data.ok && out_data.count_one == '0 && out_data.count_two == '0))
    else $error("clear did not empty both queues");

  // head flags agree with the reported counts
  a_head_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.head_one_valid == (out_data.count_one != '0) &&
                   out_data.head_two_valid == (out_data.count_two != '0)))
    else $error("head valid flag disagrees with count");

  // a failed enqueue leaves the counts unchanged
  a_full_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_ENQ && full) |=>
      (occ_one_r == $past(occ_one_r) && occ_two_r == $past(occ_two_r) && !out_data.ok))
    else $error("enqueue into full buffer changed state");

endmodule

`default_nettype wire
